### hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the winding-number polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int CoordW   = 24;  // port coordinate width
  localparam int DiffW    = 25;  // coordinate difference
  localparam int ProdW    = 50;  // one 25x25 signed product
  localparam int AccW     = 52;  // sum or difference of two products
  localparam int DistW    = 51;  // squared distance, unsigned integer (Q51.0)
  localparam int MagW     = 50;  // magnitude of the edge cross product
  localparam int SqW      = 100; // square of that magnitude
  localparam int RootW    = 26;  // distance, unsigned integer (Q26.0)
  localparam int WindW    = 11;
  localparam int WindLimit = 1023;
  localparam int CntW     = 6;

  typedef enum logic [1:0] {
    ST_OUTSIDE    = 2'd0,
    ST_INSIDE     = 2'd1,
    ST_NOT_SIMPLE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MUL,
    E_PICK,
    E_SQR,
    E_DIV,
    E_DONE
  } edge_state_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_EDGE,
    T_CLOSE_START,
    T_CLOSE,
    T_FIN,
    T_ROOT,
    T_HOLD
  } top_state_e;

  // edge unit result, valid while done is high
  typedef struct packed {
    logic             done;
    logic [DistW-1:0] dist_sq;
    logic             up;
    logic             dn;
  } edge_res_t;

endpackage

### hdl/pip_if.sv
// ----------------------------------------------------------------------------
// pip_if
// Vertex input channel and result output channel.
// ----------------------------------------------------------------------------
interface pip_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] vertex_x;
  logic signed [23:0] vertex_y;
  logic signed [23:0] query_x;
  logic signed [23:0] query_y;
  logic               last_vertex;

  modport source(output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                 input ready);
  modport sink(input valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
               output ready);
endinterface

interface pip_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [25:0] edge_distance;

  modport source(output valid, status, edge_distance, input ready);
  modport sink(input valid, status, edge_distance, output ready);
endinterface

### hdl/pip_edge.sv
// ----------------------------------------------------------------------------
// pip_edge
// Squared point-to-segment distance and winding crossing for one edge.
// One shared 25x25 multiplier, then bit-serial squaring and division.
// ----------------------------------------------------------------------------
module pip_edge import pip_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_i,
  input  logic signed [CoordW-1:0] px_i,
  input  logic signed [CoordW-1:0] py_i,
  output edge_res_t                res_o
);

  edge_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q, px_q, py_q;
  logic signed [DiffW-1:0]  dx, dy, wx, wy, ex, ey, op_a, op_b;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   den_q, tn_q, cr_q, ww_q, ee_q, prod_ext;
  logic [MagW-1:0]          mag_q, msh_q;
  logic [SqW-1:0]           sq_q, sq_next;
  logic [DistW-1:0]         rem_q, quot_q, dist_q, trial;
  logic                     up_q, dn_q;

  assign dx = DiffW'(bx_q) - DiffW'(ax_q);
  assign dy = DiffW'(by_q) - DiffW'(ay_q);
  assign wx = DiffW'(px_q) - DiffW'(ax_q);
  assign wy = DiffW'(py_q) - DiffW'(ay_q);
  assign ex = DiffW'(px_q) - DiffW'(bx_q);
  assign ey = DiffW'(py_q) - DiffW'(by_q);

  always_comb begin
    case (cnt_q)
      6'd0:    begin op_a = dx; op_b = dx; end
      6'd1:    begin op_a = dy; op_b = dy; end
      6'd2:    begin op_a = wx; op_b = dx; end
      6'd3:    begin op_a = wy; op_b = dy; end
      6'd4:    begin op_a = dx; op_b = wy; end
      6'd5:    begin op_a = dy; op_b = wx; end
      6'd6:    begin op_a = wx; op_b = wx; end
      6'd7:    begin op_a = wy; op_b = wy; end
      6'd8:    begin op_a = ex; op_b = ex; end
      6'd9:    begin op_a = ey; op_b = ey; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_ext = AccW'(prod_q);
  assign trial    = {rem_q[DistW-2:0], sq_q[SqW-1]};
  assign sq_next  = (sq_q << 1) + (msh_q[MagW-1] ? SqW'(mag_q) : SqW'(0));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      E_IDLE: if (start_i) begin
        state_d = E_MUL;
        cnt_d   = '0;
      end
      E_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(10)) state_d = E_PICK;
      end
      E_PICK: begin
        cnt_d = '0;
        if (den_q == '0 || tn_q <= 0 || tn_q >= den_q) state_d = E_DONE;
        else state_d = E_SQR;
      end
      E_SQR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(MagW - 1)) begin
          state_d = E_DIV;
          cnt_d   = '0;
        end
      end
      E_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DistW - 1)) state_d = E_DONE;
      end
      E_DONE:  state_d = E_IDLE;
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    case (state_q)
      E_IDLE: if (start_i) begin
        ax_q <= ax_i; ay_q <= ay_i; bx_q <= bx_i; by_q <= by_i;
        px_q <= px_i; py_q <= py_i;
        den_q <= '0; tn_q <= '0; cr_q <= '0; ww_q <= '0; ee_q <= '0;
      end
      E_MUL: begin
        case (cnt_q)
          6'd1, 6'd2:  den_q <= den_q + prod_ext;
          6'd3, 6'd4:  tn_q  <= tn_q + prod_ext;
          6'd5:        cr_q  <= cr_q + prod_ext;
          6'd6:        cr_q  <= cr_q - prod_ext;
          6'd7, 6'd8:  ww_q  <= ww_q + prod_ext;
          6'd9, 6'd10: ee_q  <= ee_q + prod_ext;
          default: ;
        endcase
      end
      E_PICK: begin
        up_q  <= (ay_q <= py_q) && (by_q > py_q) && (cr_q > 0);
        dn_q  <= (ay_q > py_q) && (by_q <= py_q) && (cr_q < 0);
        mag_q <= cr_q[AccW-1] ? MagW'(-cr_q) : MagW'(cr_q);
        msh_q <= cr_q[AccW-1] ? MagW'(-cr_q) : MagW'(cr_q);
        sq_q  <= '0;
        if (den_q == '0 || tn_q <= 0) dist_q <= DistW'(ww_q);
        else dist_q <= DistW'(ee_q);
      end
      E_SQR: begin
        msh_q <= msh_q << 1;
        if (cnt_q == CntW'(MagW - 1)) begin
          // quotient fits DistW bits, so the top part starts below den
          rem_q  <= DistW'(sq_next >> DistW);
          sq_q   <= sq_next << (SqW - DistW);
          quot_q <= '0;
        end else begin
          sq_q <= sq_next;
        end
      end
      E_DIV: begin
        sq_q <= sq_q << 1;
        if (trial >= DistW'(den_q)) begin
          rem_q  <= trial - DistW'(den_q);
          quot_q <= {quot_q[DistW-2:0], 1'b1};
        end else begin
          rem_q  <= trial;
          quot_q <= {quot_q[DistW-2:0], 1'b0};
        end
        if (cnt_q == CntW'(DistW - 1)) begin
          dist_q <= (trial >= DistW'(den_q)) ? {quot_q[DistW-2:0], 1'b1}
                                             : {quot_q[DistW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign res_o.done    = (state_q == E_DONE);
  assign res_o.dist_sq = dist_q;
  assign res_o.up      = up_q;
  assign res_o.dn      = dn_q;

endmodule

### hdl/pip_sqrt.sv
// ----------------------------------------------------------------------------
// pip_sqrt
// Integer square root, rounded down, one base-4 digit per cycle.
// ----------------------------------------------------------------------------
module pip_sqrt import pip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DistW-1:0] value_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int RemW = RootW + 2;

  logic               busy_q, done_q;
  logic [4:0]         cnt_q;
  logic [2*RootW-1:0] val_q;
  logic [RemW-1:0]    rem_q, rem_sh, trial;
  logic [RootW-1:0]   root_q;

  assign rem_sh = {rem_q[RemW-3:0], val_q[2*RootW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= (2*RootW)'(value_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= val_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hdl/point_in_polygon_winding_distance.sv
// ----------------------------------------------------------------------------
// point_in_polygon_winding_distance
// Winding-number point-in-polygon test with distance to the nearest edge.
// ----------------------------------------------------------------------------
// A vertex that closes one edge holds the input while the edge unit runs: 11 multiplier
// steps, 50 squaring and 51 division steps, a pick and a done state; squaring and division
// are skipped when the nearest point is an endpoint. A first vertex that is not the last
// leaves the input ready. A last vertex then adds the closing edge, a decide state, the
// square root when outside, and a load of the result register once the output is free.
// Reset is asynchronous, active low, and starts a fresh polygon.
module point_in_polygon_winding_distance import pip_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  pip_in_if.sink    in_i,
  pip_out_if.source out_o
);

  localparam int EffBits = (COORD_BITS > CoordW) ? CoordW : COORD_BITS;
  localparam int Shift   = CoordW - EffBits;

  top_state_e state_q, state_d;

  logic signed [CoordW-1:0] vx_sh, vy_sh, qx_sh, qy_sh, vx, vy, qx, qy;
  logic signed [CoordW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, pt_x_q, pt_y_q;
  logic signed [CoordW-1:0] ax, ay, bx, by;
  logic signed [WindW-1:0]  wind_q;
  logic [DistW-1:0]         min_q;
  logic                     hit_q, at_first_q, last_q;
  logic                     accept, edge_start, root_start, root_done;
  logic [RootW-1:0]         root;
  edge_res_t                eres;
  status_e                  res_status_q;
  logic [RootW-1:0]         res_dist_q;
  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [RootW-1:0]         out_dist_q;
  logic                     out_load;

  assign vx_sh = in_i.vertex_x << Shift;
  assign vy_sh = in_i.vertex_y << Shift;
  assign qx_sh = in_i.query_x << Shift;
  assign qy_sh = in_i.query_y << Shift;
  assign vx    = vx_sh >>> Shift;
  assign vy    = vy_sh >>> Shift;
  assign qx    = qx_sh >>> Shift;
  assign qy    = qy_sh >>> Shift;

  assign in_i.ready = (state_q == T_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == T_HOLD) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    edge_start = 1'b0;
    root_start = 1'b0;
    ax = prev_x_q; ay = prev_y_q; bx = vx; by = vy;
    case (state_q)
      T_IDLE: if (accept) begin
        if (!at_first_q) begin
          edge_start = 1'b1;
          state_d    = T_EDGE;
        end else if (in_i.last_vertex) begin
          state_d = T_CLOSE_START;
        end
      end
      T_EDGE: if (eres.done) state_d = last_q ? T_CLOSE_START : T_IDLE;
      T_CLOSE_START: begin
        bx = first_x_q; by = first_y_q;
        edge_start = 1'b1;
        state_d    = T_CLOSE;
      end
      T_CLOSE: if (eres.done) state_d = T_FIN;
      T_FIN: begin
        if (!hit_q && wind_q == '0) begin
          root_start = 1'b1;
          state_d    = T_ROOT;
        end else begin
          state_d = T_HOLD;
        end
      end
      T_ROOT: if (root_done) state_d = T_HOLD;
      T_HOLD: if (out_load) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  pip_edge u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (edge_start),
    .ax_i    (ax),
    .ay_i    (ay),
    .bx_i    (bx),
    .by_i    (by),
    .px_i    (pt_x_q),
    .py_i    (pt_y_q),
    .res_o   (eres)
  );

  pip_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (min_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_IDLE;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      pt_x_q       <= '0;
      pt_y_q       <= '0;
      wind_q       <= '0;
      min_q        <= '1;
      hit_q        <= 1'b0;
      at_first_q   <= 1'b1;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OUTSIDE;
      out_status_q <= ST_OUTSIDE;
    end else begin
      state_q <= state_d;
      if (accept) begin
        prev_x_q   <= vx;
        prev_y_q   <= vy;
        last_q     <= in_i.last_vertex;
        at_first_q <= in_i.last_vertex;
        if (at_first_q) begin
          pt_x_q    <= qx;
          pt_y_q    <= qy;
          first_x_q <= vx;
          first_y_q <= vy;
          wind_q    <= '0;
          min_q     <= '1;
          hit_q     <= (vx == qx) && (vy == qy);
        end else if ((vx == pt_x_q) && (vy == pt_y_q)) begin
          hit_q <= 1'b1;
        end
      end
      if (eres.done) begin
        if (eres.dist_sq < min_q) min_q <= eres.dist_sq;
        if (eres.up && wind_q < WindW'(WindLimit)) wind_q <= wind_q + 1'b1;
        if (eres.dn && wind_q > -WindW'(WindLimit)) wind_q <= wind_q - 1'b1;
      end
      if (state_q == T_FIN) begin
        if (hit_q || wind_q == WindW'(1) || wind_q == -WindW'(1))
          res_status_q <= ST_INSIDE;
        else if (wind_q == '0)
          res_status_q <= ST_OUTSIDE;
        else
          res_status_q <= ST_NOT_SIMPLE;
      end
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_FIN) res_dist_q <= '0;
    else if (root_done) res_dist_q <= root;
    if (out_load) out_dist_q <= res_dist_q;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.edge_distance = out_dist_q;

  a_edge_done_when_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eres.done |-> (state_q == T_EDGE || state_q == T_CLOSE))
    else $error("edge result outside an edge wait");

  a_wind_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wind_q <= WindW'(WindLimit)) && (wind_q >= -WindW'(WindLimit)))
    else $error("winding count out of range");

  a_no_dist_unless_outside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OUTSIDE) |-> (out_dist_q == '0))
    else $error("distance posted for inside or not simple polygon");

  a_root_only_outside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_start |=> (res_status_q == ST_OUTSIDE))
    else $error("square root started for a polygon that is not outside");

endmodule
